// File: rtl/core/sha_pkg.sv
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int MsgWords   = 16;
	localparam int HashWords  = 8;
	localparam int Rounds     = 64;

	localparam logic [0:0] OP_ABSORB = 1'b0;
	localparam logic [0:0] OP_FINISH = 1'b1;
	localparam logic [7:0] PAD_BYTE  = 8'h80;

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	typedef logic [31:0] hash_state_t [8];

	// handshake between the byte front end and the compression core
	typedef struct packed {
		logic start;
		logic reset_hash;
	} core_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_rsp_t;

endpackage

// File: rtl/core/sha_ram.sv
module sha_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/core/sha_core.sv
module sha_core
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  core_req_t   req,
	output core_rsp_t   rsp,
	// message schedule memory, one 32-bit word per entry
	output logic        w_we,
	output logic [3:0]  w_waddr,
	output logic [31:0] w_wdata,
	output logic [3:0]  w_raddr,
	input  logic [31:0] w_rdata,
	input  logic [2:0]  hsel,
	output logic [31:0] hword
);
	typedef enum logic [3:0] {
		C_IDLE  = 4'b0001,
		C_LOAD  = 4'b0010,
		C_ROUND = 4'b0100,
		C_ADD   = 4'b1000
	} cstate_t;

	cstate_t     state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [16]; // sliding window of schedule words
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [31:0] wcur, s0, s1, t1, t2, wnext;

	// window: win_q[15] is w[i-1], win_q[0] is w[i-16]
	assign s0 = ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3);
	assign s1 = ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10);
	assign wnext = s1 + win_q[9] + s0 + win_q[0];
	// first 16 rounds rotate the loaded block, so w[i] sits at win_q[0]
	assign wcur = (cnt_q < 7'd16) ? win_q[0] : wnext;

	always_comb begin
		t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_const(cnt_q[5:0]) + wcur;
		t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign w_we    = 1'b0;
	assign w_waddr = '0;
	assign w_wdata = '0;
	assign w_raddr = cnt_q[3:0];
	assign hword   = h_q[hsel];
	assign rsp     = '{busy: (state_q != C_IDLE), done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			done_q <= (state_q == C_ADD);
			if (req.reset_hash)
				for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						cnt_q   <= 7'd1;
						state_q <= C_LOAD;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				// memory read data arrives the cycle after its address; words 0..15 stream in
				C_LOAD: begin
					for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
					win_q[15] <= w_rdata;
					if (cnt_q == 7'd16) begin
						cnt_q   <= '0;
						state_q <= C_ROUND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_ROUND: begin
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					if (cnt_q < 7'd16) begin
						// rotate so that win_q[0] presents w[i] next
						for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
						win_q[15] <= win_q[0];
					end else begin
						for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
						win_q[15] <= wnext;
					end
					if (cnt_q == 7'd63) state_q <= C_ADD;
					cnt_q <= cnt_q + 7'd1;
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/sha256_stream_hash.sv
// SHA-256 over a byte stream. opcode 0 absorbs data_byte, opcode 1 pads the
// message and returns the digest as eight 32-bit words, word_index 0 first,
// last_word set on the eighth; the hasher then starts a fresh message. The
// 64th byte of a block runs the compression: the schedule words are loaded
// from the block memory, then come the rounds, an add step and a hand-back
// step, and the input is held off throughout. A finish writes the padding
// one word a cycle (1 to 16 words), then compresses; a tail of 56 or more
// bytes adds a wait state, 16 padding writes and a second compression. The
// eight words then come straight from the hash registers, one per accepted
// word. The block memory holds 16 words of 32 bits; bytes are merged into a
// word register and written when a word completes.
module sha256_stream_hash
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_COMP = 6'b000010,
		S_PADW = 6'b000100,
		S_FCMP = 6'b001000,
		S_OUT  = 6'b010000,
		S_WAIT = 6'b100000
	} state_t;

	state_t      state_q;
	logic [5:0]  count_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	logic [23:0] part_q;   // bytes already taken of the current word
	logic [3:0]  pw_q;     // padding word address
	logic        two_q;    // an extra padding block is pending
	logic [2:0]  oi_q;
	core_req_t   req;
	core_rsp_t   rsp;

	logic        c_we, m_we;
	logic [3:0]  c_waddr, c_raddr, m_waddr;
	logic [31:0] c_wdata, m_wdata, rdata, hword;

	sha_core u_core (
		.clk, .arst_n, .req, .rsp,
		.w_we(c_we), .w_waddr(c_waddr), .w_wdata(c_wdata),
		.w_raddr(c_raddr), .w_rdata(rdata),
		.hsel(oi_q), .hword
	);

	sha_ram #(.Width(32), .Depth(MsgWords)) u_blk (
		.clk, .we(m_we | c_we), .waddr(m_we ? m_waddr : c_waddr),
		.wdata(m_we ? m_wdata : c_wdata), .raddr(c_raddr), .rdata
	);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign digest_word = hword;
	assign word_index  = oi_q;
	assign last_word   = (oi_q == 3'd7);

	logic acc;
	assign acc = in_valid & in_ready;

	// padding word content for word pw_q, given the tail position
	logic [31:0] padw;
	logic [3:0]  tw;
	logic [1:0]  tb;
	assign tw = count_q[5:2];
	assign tb = count_q[1:0];
	always_comb begin
		padw = '0;
		if (!two_q && pw_q == 4'd14) padw = total_q[63:32];
		else if (!two_q && pw_q == 4'd15) padw = total_q[31:0];
		else if (pw_q == tw) begin
			case (tb)
				2'd0: padw = {PAD_BYTE, 24'h0};
				2'd1: padw = {part_q[23:16], PAD_BYTE, 16'h0};
				2'd2: padw = {part_q[23:8], PAD_BYTE, 8'h0};
				default: padw = {part_q, PAD_BYTE};
			endcase
		end
	end

	always_comb begin
		m_we    = 1'b0;
		m_waddr = pw_q;
		m_wdata = padw;
		req     = '0;
		if (state_q == S_IDLE && acc && opcode == OP_ABSORB && tb == 2'd3) begin
			m_we    = 1'b1;
			m_waddr = tw;
			m_wdata = {part_q, data_byte};
			req.start = (count_q == 6'd63);
		end
		if (state_q == S_PADW) begin
			m_we = 1'b1;
			if (pw_q == 4'd15) req.start = 1'b1;
		end
		if (state_q == S_OUT && out_ready && oi_q == 3'd7) req.reset_hash = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			bits_q  <= '0;
			total_q <= '0;
			part_q  <= '0;
			oi_q    <= '0;
			two_q   <= 1'b0;
			pw_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc && opcode == OP_ABSORB) begin
						case (tb)
							2'd0: part_q[23:16] <= data_byte;
							2'd1: part_q[15:8]  <= data_byte;
							2'd2: part_q[7:0]   <= data_byte;
							default: ;
						endcase
						count_q <= count_q + 6'd1;
						if (count_q == 6'd63) state_q <= S_COMP;
					end else if (acc) begin
						total_q <= bits_q + {55'd0, count_q, 3'd0};
						two_q   <= (count_q > 6'd55);
						pw_q    <= tw;
						state_q <= S_PADW;
					end
				end
				S_COMP: begin
					if (rsp.done) begin
						bits_q  <= bits_q + 64'd512;
						state_q <= S_IDLE;
					end
				end
				S_PADW: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == 4'd15) state_q <= S_FCMP;
				end
				S_FCMP: begin
					if (rsp.done) begin
						if (two_q) begin
							// second block: all zero but the length
							two_q   <= 1'b0;
							count_q <= 6'd0;
							pw_q    <= '0;
							state_q <= S_WAIT;
						end else begin
							oi_q    <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_WAIT: begin
					// park the tail word at 15 so the pad byte does not appear again
					pw_q    <= pw_q;
					state_q <= S_PADW;
					count_q <= 6'd60;
				end
				S_OUT: begin
					if (out_ready) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == 3'd7) begin
							state_q <= S_IDLE;
							count_q <= '0;
							bits_q  <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/sha_checker.sv
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  word_index,
	input logic        last_word,
	input logic [31:0] digest_word
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word mismatch");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during digest");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid)
		else $error("digest burst broken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(digest_word))
		else $error("word changed while stalled");
endmodule

bind sha256_stream_hash sha_checker u_chk (.*);
